// ===== hdl/rrl_pkg.sv =====
// rrl_pkg: shared types and constants of the response rate limiter
// used by rrl_datapath, rrl_ctrl and response_rate_limiter_unit
package rrl_pkg;

  // time base: 64 ticks per second
  localparam int unsigned TICK_SHIFT  = 6;
  localparam logic [31:0] ONE_SEC     = 32'd64;
  localparam int unsigned SCALE_SHIFT = 4;
  localparam logic [16:0] HIT_CEILING = 17'd65535;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_RATE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_RATE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLIP_PERIOD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_ONLY     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMITER_ENABLED = 3'd4;

  // reset values of the configuration registers
  localparam logic [15:0] RESPONSE_RATE_RST = 16'd5;
  localparam logic [15:0] ERROR_RATE_RST    = 16'd5;
  localparam logic [15:0] SLIP_PERIOD_RST   = 16'd2;

  typedef enum logic [1:0] {
    VERDICT_PROCEED      = 2'd0,
    VERDICT_DROP         = 2'd1,
    VERDICT_SLIP         = 2'd2,
    VERDICT_PROCEED_DROP = 2'd3
  } verdict_t;

  typedef struct packed {
    logic        mode;
    logic [9:0]  entry_index;
    logic        is_error;
    logic [31:0] now_tick;
    logic        exempt;
    logic        slip_coin;
  } in_item_t;

  typedef struct packed {
    verdict_t verdict;
    logic     truncate;
  } out_item_t;

  // one table slot as stored in the memory
  typedef struct packed {
    logic        valid;
    logic [31:0] window_start;
    logic [31:0] last_seen;
    logic [15:0] hit_count;
    logic [15:0] slip_remain;
  } entry_t;

  // how an item is handled once its slot has been read
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FRESH = 2'd2,
    KIND_KNOWN = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_SWEEP = 3'd0,
    ST_IDLE  = 3'd1,
    ST_LOAD  = 3'd2,
    ST_DMUL  = 3'd3,
    ST_APPLY = 3'd4,
    ST_SCALE = 3'd5,
    ST_LMUL  = 3'd6,
    ST_DONE  = 3'd7
  } state_t;

  typedef struct packed {
    logic sweep;
    logic load_item;
    logic load_entry;
    logic decay_mul;
    logic decay_apply;
    logic scale;
    logic limit_mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic  sweep_done;
    kind_t kind;
    logic  decay_due;
    logic  out_free;
  } stat_t;

endpackage

// ===== hdl/rrl_ram.sv =====
// rrl_ram: generic single-write, single-read memory with registered read
// no dependencies
module rrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rrl_datapath.sv =====
// rrl_datapath: configuration registers, slot table, shared multiplier
// and verdict logic; depends on rrl_pkg and rrl_ram
module rrl_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rrl_pkg::in_item_t                   in_data,
  input  logic                                cfg_valid,
  input  logic [rrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data,
  input  rrl_pkg::cmd_t                       cmd,
  output rrl_pkg::stat_t                      stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rrl_pkg::out_item_t                  out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [31:0]   DEPTH_W   = 32'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  // configuration
  logic [15:0] response_rate;
  logic [15:0] error_rate;
  logic [15:0] slip_period;
  logic        report_only;
  logic        limiter_enabled;

  // item and working registers
  rrl_pkg::in_item_t item;
  logic              in_range;
  logic [AW-1:0]     slot;
  logic [31:0]       win;
  logic [15:0]       hit;
  logic [15:0]       slip;
  logic [31:0]       tsd;
  logic [47:0]       prod;
  logic [31:0]       ticks;
  logic [16:0]       hits;
  logic              scaled;
  rrl_pkg::kind_t    kind_q;
  logic [AW-1:0]     sweep_cnt;

  // memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  rrl_pkg::entry_t   ram_wdata;
  logic [31:0]       idx_in;
  rrl_pkg::entry_t   rd;

  // combinational values
  rrl_pkg::kind_t    kind_c;
  logic [31:0]       tsd_c;
  logic [31:0]       mul_a;
  logic [15:0]       mul_b;
  logic [47:0]       mul_p;
  logic [31:0]       ticks_c;
  logic [16:0]       hits_c;
  logic              over_c;
  logic [41:0]       limit_c;
  logic [15:0]       slip_dec;
  logic [15:0]       hit_new;
  logic [15:0]       slip_new;
  rrl_pkg::out_item_t result_c;

  assign idx_in = 32'(in_data.entry_index);

  rrl_ram #(
    .WIDTH ($bits(rrl_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load_item),
    .raddr (idx_in[AW-1:0]),
    .rdata (rd)
  );

  // slot classification while the read data is fresh
  always_comb begin
    if (!in_range) begin
      kind_c = rrl_pkg::KIND_PASS;
    end else if (item.mode) begin
      kind_c = rrl_pkg::KIND_CLEAR;
    end else if (!limiter_enabled || item.exempt) begin
      kind_c = rrl_pkg::KIND_PASS;
    end else if (!rd.valid) begin
      kind_c = rrl_pkg::KIND_FRESH;
    end else begin
      kind_c = rrl_pkg::KIND_KNOWN;
    end
  end

  assign tsd_c = (item.now_tick - rd.window_start) & ~(rrl_pkg::ONE_SEC - 32'd1);

  // shared multiplier: decay uses whole seconds times response rate
  assign mul_a = cmd.decay_mul ? (tsd >> rrl_pkg::TICK_SHIFT) : ticks;
  assign mul_b = cmd.decay_mul ? response_rate :
                 (item.is_error ? error_rate : response_rate);
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  assign ticks_c = item.now_tick - win;
  assign hits_c  = {1'b0, hit} + 17'd1;
  assign over_c  = (hits_c >= rrl_pkg::HIT_CEILING);

  // verdict from hits against limit
  assign limit_c  = prod[47:rrl_pkg::TICK_SHIFT];
  assign slip_dec = slip - 16'd1;

  always_comb begin
    result_c.verdict  = rrl_pkg::VERDICT_PROCEED;
    result_c.truncate = 1'b0;
    hit_new           = hit;
    slip_new          = slip;
    if (kind_q == rrl_pkg::KIND_KNOWN) begin
      if (42'(hits) <= limit_c) begin
        hit_new = hits[15:0];
      end else begin
        result_c.verdict = report_only ? rrl_pkg::VERDICT_PROCEED_DROP :
                                         rrl_pkg::VERDICT_DROP;
        if (slip_period != 16'd0) begin
          slip_new = slip_dec;
          if (slip_dec == 16'd0) begin
            slip_new = slip_period;
            if (item.slip_coin) begin
              result_c.verdict  = rrl_pkg::VERDICT_SLIP;
              result_c.truncate = !report_only;
              hit_new           = hits[15:0];
            end
          end
        end
      end
    end
  end

  // table write: clearing sweep or end of an item
  always_comb begin
    ram_wdata = '0;
    unique case (kind_q)
      rrl_pkg::KIND_FRESH: begin
        ram_wdata.valid        = 1'b1;
        ram_wdata.window_start = item.now_tick - rrl_pkg::ONE_SEC;
        ram_wdata.last_seen    = item.now_tick;
        ram_wdata.hit_count    = 16'd0;
        ram_wdata.slip_remain  = slip_period;
      end
      rrl_pkg::KIND_KNOWN: begin
        ram_wdata.valid        = 1'b1;
        ram_wdata.window_start = win;
        ram_wdata.last_seen    = item.now_tick;
        ram_wdata.hit_count    = hit_new;
        ram_wdata.slip_remain  = slip_new;
      end
      default: begin
        ram_wdata = '0;
      end
    endcase
    if (cmd.sweep) begin
      ram_wdata = '0;
    end
  end

  assign ram_we    = cmd.sweep || (cmd.finish && (kind_q != rrl_pkg::KIND_PASS));
  assign ram_waddr = cmd.sweep ? sweep_cnt : slot;

  assign stat.sweep_done = (sweep_cnt == LAST_SLOT);
  assign stat.kind       = kind_c;
  assign stat.decay_due  = ((item.now_tick - rd.last_seen) >= rrl_pkg::ONE_SEC);
  assign stat.out_free   = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      response_rate   <= rrl_pkg::RESPONSE_RATE_RST;
      error_rate      <= rrl_pkg::ERROR_RATE_RST;
      slip_period     <= rrl_pkg::SLIP_PERIOD_RST;
      report_only     <= 1'b0;
      limiter_enabled <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rrl_pkg::CFG_RESPONSE_RATE:   response_rate   <= cfg_data;
        rrl_pkg::CFG_ERROR_RATE:      error_rate      <= cfg_data;
        rrl_pkg::CFG_SLIP_PERIOD:     slip_period     <= cfg_data;
        rrl_pkg::CFG_REPORT_ONLY:     report_only     <= cfg_data[0];
        rrl_pkg::CFG_LIMITER_ENABLED: limiter_enabled <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + AW'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item     <= in_data;
      slot     <= idx_in[AW-1:0];
      in_range <= (idx_in < DEPTH_W);
    end
    if (cmd.load_entry) begin
      win    <= rd.window_start;
      hit    <= rd.hit_count;
      slip   <= rd.slip_remain;
      tsd    <= tsd_c;
      kind_q <= kind_c;
    end
    if (cmd.decay_mul || cmd.limit_mul) begin
      prod <= mul_p;
    end
    if (cmd.decay_apply) begin
      if (prod > 48'(hit)) begin
        hit <= 16'd0;
        win <= item.now_tick - rrl_pkg::ONE_SEC;
      end else begin
        hit <= hit - prod[15:0];
        win <= win + tsd;
      end
    end
    if (cmd.scale) begin
      scaled <= over_c;
      ticks  <= over_c ? (ticks_c >> rrl_pkg::SCALE_SHIFT) : ticks_c;
      hits   <= over_c ? (hits_c >> rrl_pkg::SCALE_SHIFT) : hits_c;
    end
    // scaled window and hit count settle beside the limit product
    if (cmd.limit_mul && scaled) begin
      win <= item.now_tick - ticks;
      hit <= hits[15:0];
    end
    if (cmd.finish) begin
      out_data <= result_c;
    end
  end

endmodule

// ===== hdl/rrl_ctrl.sv =====
// rrl_ctrl: sequencer of the response rate limiter
// depends on rrl_pkg
module rrl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rrl_pkg::stat_t stat,
  output rrl_pkg::cmd_t  cmd
);

  rrl_pkg::state_t state;
  rrl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrl_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != rrl_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      rrl_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_next = rrl_pkg::ST_IDLE;
        end
      end
      rrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = rrl_pkg::ST_LOAD;
        end
      end
      rrl_pkg::ST_LOAD: begin
        cmd.load_entry = 1'b1;
        if (stat.kind != rrl_pkg::KIND_KNOWN) begin
          state_next = rrl_pkg::ST_DONE;
        end else if (stat.decay_due) begin
          state_next = rrl_pkg::ST_DMUL;
        end else begin
          state_next = rrl_pkg::ST_SCALE;
        end
      end
      rrl_pkg::ST_DMUL: begin
        cmd.decay_mul = 1'b1;
        state_next    = rrl_pkg::ST_APPLY;
      end
      rrl_pkg::ST_APPLY: begin
        cmd.decay_apply = 1'b1;
        state_next      = rrl_pkg::ST_SCALE;
      end
      rrl_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = rrl_pkg::ST_LMUL;
      end
      rrl_pkg::ST_LMUL: begin
        cmd.limit_mul = 1'b1;
        state_next    = rrl_pkg::ST_DONE;
      end
      rrl_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = rrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rrl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/response_rate_limiter_unit.sv =====
// response_rate_limiter_unit: top level of the per-flow response rate limiter
// depends on rrl_pkg, rrl_ctrl and rrl_datapath (which holds rrl_ram)
//
// usage
//   in channel: in_valid / in_stall / in_data; one check or clear item per
//     transfer, naming a table slot resolved by an external key lookup
//   out channel: out_valid / out_stall / out_data; one verdict per item,
//     in item order, held in an output register while out_stall is high
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
//     always high, write only while no item is in flight
// timing
//   the slot is read on the transfer edge; pass, clear and new slots go LOAD,
//   DONE; known slots go LOAD, SCALE, LMUL, DONE, with DMUL and APPLY before
//   SCALE if idle decay is due; the result is loaded in DONE and the next item
//   is taken in IDLE after it, so items go one at a time, set by the slot
//   read-modify-write and the shared 32x16 multiplier used for decay and limit
//   a waiting result does not block the next transfer; only the final step of
//   the following item waits while out_stall holds the output register
// reset
//   rst (synchronous) restores the configuration defaults, then the slot
//   table is swept clear slot by slot with in_stall high
module response_rate_limiter_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rrl_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rrl_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  rrl_pkg::cmd_t  cmd;
  rrl_pkg::stat_t stat;

  // registers take a write on any cycle
  assign cfg_ready = 1'b1;

  // sequencer: sweep, accept, read, decay, scale, limit, finish
  rrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table, arithmetic and output register
  rrl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
